[sv/pte_pkg.sv]
// Shared types, constants and codes of the piece table edit engine.
package pte_pkg;

  localparam int MAX_PIECES  = 64;
  localparam int OFFSET_BITS = 32;
  localparam int IDX_W       = $clog2(MAX_PIECES);
  localparam int CNT_W       = $clog2(MAX_PIECES + 1);

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [2:0] {
    FN_INSERT  = 3'd0,
    FN_ERASE   = 3'd1,
    FN_REPLACE = 3'd2,
    FN_READ    = 3'd3,
    FN_ADOPT   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_APPLIED   = 3'd0,
    ST_NOOP      = 3'd1,
    ST_CONFLICT  = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_RD,
    S_END,
    S_LEFT,
    S_INS,
    S_RIGHT,
    S_TAIL,
    S_FLUSH,
    S_COMMIT,
    S_RDE,
    S_RDE2,
    S_DONE
  } state_e;

  typedef struct packed {
    logic src;
    off_t beg;
    off_t len;
  } piece_t;

  typedef struct packed {
    logic   vld;
    piece_t pc;
  } emit_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    piece_t           data;
  } wr_t;

endpackage

[sv/pte_if.sv]
// Request and response channel interfaces of the piece table edit engine.
interface pte_req_if import pte_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] func;
  off_t       pos_a;
  off_t       pos_b;
  off_t       text_len;
  off_t       expected_version;

  modport source (output valid, func, pos_a, pos_b, text_len, expected_version,
                  input ready);
  modport sink   (input valid, func, pos_a, pos_b, text_len, expected_version,
                  output ready);
endinterface

interface pte_rsp_if import pte_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  off_t       doc_length;
  cnt_t       entry_count;
  off_t       doc_version;
  logic       entry_source;
  off_t       entry_start;
  off_t       entry_length;

  modport source (output valid, status, doc_length, entry_count, doc_version,
                  entry_source, entry_start, entry_length, input ready);
  modport sink   (input valid, status, doc_length, entry_count, doc_version,
                  entry_source, entry_start, entry_length, output ready);
endinterface

[sv/pte_ram.sv]
// Generic single write port, single read port RAM with registered read.
module pte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/pte_merge.sv]
// Compaction stage: drops empty pieces, merges contiguous ones, writes the new table.
module pte_merge import pte_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  clr_i,
  input  emit_t emit_i,
  input  logic  flush_i,
  output wr_t   wr_o,
  output cnt_t  cnt_o,
  output logic  ovf_o
);

  logic   pend_v_q;
  piece_t pend_q;
  off_t   pend_end_q;
  cnt_t   cnt_q;
  logic   ovf_q;

  logic take, join_pc, push, room;

  // decide merge or push of the held piece
  assign take    = emit_i.vld && (emit_i.pc.len != '0);
  assign join_pc = pend_v_q && (pend_q.src == emit_i.pc.src) &&
                   (pend_end_q == emit_i.pc.beg);
  assign push    = pend_v_q && ((take && !join_pc) || flush_i);
  assign room    = cnt_q < CNT_W'(MAX_PIECES);

  assign wr_o.we   = push && room;
  assign wr_o.addr = cnt_q[IDX_W-1:0];
  assign wr_o.data = pend_q;
  assign cnt_o     = cnt_q;
  assign ovf_o     = ovf_q;

  // control: held flag, count, overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
    end else if (clr_i) begin
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
    end else begin
      if (push) begin
        if (room) begin
          cnt_q <= cnt_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (take) begin
        pend_v_q <= 1'b1;
      end else if (flush_i) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  // held piece: extend or replace
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (join_pc) begin
        pend_q.len <= pend_q.len + emit_i.pc.len;
        pend_end_q <= pend_end_q + emit_i.pc.len;
      end else begin
        pend_q     <= emit_i.pc;
        pend_end_q <= emit_i.pc.beg + emit_i.pc.len;
      end
    end
  end

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> cnt_q == CNT_W'(MAX_PIECES))
    else $error("overflow flagged below full table");

  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_i && !clr_i) |=> !pend_v_q)
    else $error("held piece survives flush");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |-> cnt_q < CNT_W'(MAX_PIECES))
    else $error("table write past last entry");

endmodule

[sv/piece_table_edit_engine.sv]
// Piece table edit engine: request decode, table walk sequencer and state.
//
// Requests enter on the req channel (func, pos_a, pos_b, text_len,
// expected_version); one response per request leaves on rsp. The piece table
// sits in two RAM banks: an edit reads the active bank entry by entry, splits
// pieces around the clamped range, places the inserted piece, and streams the
// result through the compaction stage into the other bank. The banks swap on
// success; on table overflow the new bank is dropped and nothing changes.
// Each edit walks every piece through read, end offset, left part, insert and
// right part steps, then places any pending insert, flushes and commits. A read
// entry is a decode step then the RAM read and capture steps; adopt and edits
// rejected at the check end after the check; bad indexes and unused codes end
// after decode. One request is worked at a time; req.ready is high while the
// sequencer is idle, which it enters as the response is registered.
// Reset clears the piece count, document length, add-buffer fill and
// version; RAM contents are not cleared, only entries below the count are
// read. A finished response waits in the output register while the next
// request is taken; a stalled receiver holds that register and the next
// request waits in its last step until the register frees.
module piece_table_edit_engine import pte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pte_req_if.sink   req,
  pte_rsp_if.source rsp
);

  state_e state_q, state_d;

  logic [2:0] func_q;
  off_t       pa_q, pb_q, len_q, expv_q;
  off_t       s_q, e_q, done_q, end_q, rskip_q, newtot_q;
  logic       ins_q, insd_q;
  cnt_t       idx_q;
  status_e    status_q;
  piece_t     ent_q;

  off_t total_q, addf_q, ver_q;
  cnt_t fill_q;
  logic sel_q;

  logic       rsp_vld_q;
  logic [2:0] rsp_status_q;
  off_t       rsp_len_q, rsp_ver_q;
  cnt_t       rsp_cnt_q;
  piece_t     rsp_ent_q;

  // datapath helpers
  off_t                   s_c, e_c, sa_c, ea_c, cut_c, rest_c, left_c;
  logic [OFFSET_BITS:0]   addsum_c, docsum_c;
  logic                   ins_c, noop_c, ovf_c, idx_ok_c, adopt_ok_c;
  piece_t                 rd_pc, rd0, rd1, adopt_pc;
  emit_t                  emit;
  wr_t                    mwr;
  cnt_t                   mcnt;
  logic                   movf;
  logic                   accept, re, flush, adopt_we, commit, out_free;
  logic [IDX_W-1:0]       raddr;

  assign accept   = req.valid && req.ready;
  assign out_free = !rsp_vld_q || rsp.ready;

  // clamp and normalize the range
  always_comb begin
    sa_c = (pa_q < total_q) ? pa_q : total_q;
    ea_c = (pb_q < total_q) ? pb_q : total_q;
    if (func_q == FN_INSERT) begin
      ea_c = sa_c;
    end
    if (ea_c < sa_c) begin
      s_c = ea_c;
      e_c = sa_c;
    end else begin
      s_c = sa_c;
      e_c = ea_c;
    end
  end

  // edit checks
  assign cut_c      = e_q - s_q;
  assign rest_c     = total_q - cut_c;
  assign ins_c      = (func_q != FN_ERASE) && (len_q != '0);
  assign noop_c     = (cut_c == '0) && !ins_c;
  assign addsum_c   = {1'b0, addf_q} + {1'b0, len_q};
  assign docsum_c   = {1'b0, rest_c} + {1'b0, len_q};
  assign ovf_c      = ins_c && (addsum_c[OFFSET_BITS] || docsum_c[OFFSET_BITS]);
  assign idx_ok_c   = pa_q < OFFSET_BITS'(fill_q);
  assign adopt_ok_c = expv_q == ver_q;
  assign left_c     = ((s_q - done_q) < rd_pc.len) ? (s_q - done_q) : rd_pc.len;

  assign rd_pc    = sel_q ? rd1 : rd0;
  assign adopt_pc = '{src: 1'b0, beg: '0, len: len_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_PREP;
      S_PREP: begin
        priority if (func_q == FN_INSERT || func_q == FN_ERASE ||
                     func_q == FN_REPLACE || func_q == FN_ADOPT) begin
          state_d = S_CHECK;
        end else if (func_q == FN_READ && idx_ok_c) begin
          state_d = S_RDE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CHECK: begin
        priority if (func_q == FN_ADOPT || noop_c || ovf_c) begin
          state_d = S_DONE;
        end else if (fill_q == '0) begin
          state_d = S_TAIL;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD:     state_d = S_END;
      S_END:    state_d = S_LEFT;
      S_LEFT:   state_d = S_INS;
      S_INS:    state_d = S_RIGHT;
      S_RIGHT:  state_d = (idx_q + 1'b1 == fill_q) ? S_TAIL : S_RD;
      S_TAIL:   state_d = S_FLUSH;
      S_FLUSH:  state_d = S_COMMIT;
      S_COMMIT: state_d = S_DONE;
      S_RDE:    state_d = S_RDE2;
      S_RDE2:   state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    re       = 1'b0;
    raddr    = idx_q[IDX_W-1:0];
    flush    = 1'b0;
    adopt_we = 1'b0;
    commit   = 1'b0;
    emit     = '{vld: 1'b0, pc: rd_pc};
    unique case (state_q)
      S_RD:  re = 1'b1;
      S_RDE: begin
        re    = 1'b1;
        raddr = pa_q[IDX_W-1:0];
      end
      S_CHECK: adopt_we = (func_q == FN_ADOPT) && adopt_ok_c && (len_q != '0);
      S_LEFT: begin
        emit.vld    = done_q < s_q;
        emit.pc.len = left_c;
      end
      S_INS: begin
        emit.vld = ins_q && !insd_q && (end_q > s_q);
        emit.pc  = '{src: 1'b1, beg: addf_q, len: len_q};
      end
      S_RIGHT: begin
        emit.vld    = end_q > e_q;
        emit.pc.beg = rd_pc.beg + rskip_q;
        emit.pc.len = rd_pc.len - rskip_q;
      end
      S_TAIL: begin
        emit.vld = ins_q && !insd_q;
        emit.pc  = '{src: 1'b1, beg: addf_q, len: len_q};
      end
      S_FLUSH:  flush  = 1'b1;
      S_COMMIT: commit = !movf;
      default: ;
    endcase
  end

  assign req.ready = state_q == S_IDLE;

  // two banks: merge writes the idle one, adopt writes the active one
  pte_ram #(.WIDTH($bits(piece_t)), .DEPTH(MAX_PIECES)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (sel_q ? mwr.we : adopt_we),
    .waddr_i (sel_q ? mwr.addr : IDX_W'(0)),
    .wdata_i (sel_q ? mwr.data : adopt_pc),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd0)
  );

  pte_ram #(.WIDTH($bits(piece_t)), .DEPTH(MAX_PIECES)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (sel_q ? adopt_we : mwr.we),
    .waddr_i (sel_q ? IDX_W'(0) : mwr.addr),
    .wdata_i (sel_q ? adopt_pc : mwr.data),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd1)
  );

  pte_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (accept),
    .emit_i  (emit),
    .flush_i (flush),
    .wr_o    (mwr),
    .cnt_o   (mcnt),
    .ovf_o   (movf)
  );

  // control and document state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      addf_q    <= '0;
      ver_q     <= '0;
      fill_q    <= '0;
      sel_q     <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (adopt_we || (state_q == S_CHECK && func_q == FN_ADOPT && adopt_ok_c)) begin
        fill_q  <= (len_q != '0) ? CNT_W'(1) : '0;
        total_q <= len_q;
        addf_q  <= '0;
        ver_q   <= ver_q + 1'b1;
      end
      if (commit) begin
        sel_q   <= !sel_q;
        fill_q  <= mcnt;
        total_q <= newtot_q;
        if (ins_q) begin
          addf_q <= addf_q + len_q;
        end
        ver_q <= ver_q + 1'b1;
      end
      if (state_q == S_DONE && out_free) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // request, walk and response registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req.func;
      pa_q   <= req.pos_a;
      pb_q   <= req.pos_b;
      len_q  <= req.text_len;
      expv_q <= req.expected_version;
      ent_q  <= '0;
      insd_q <= 1'b0;
      idx_q  <= '0;
      done_q <= '0;
    end
    unique case (state_q)
      S_PREP: begin
        s_q      <= s_c;
        e_q      <= e_c;
        status_q <= (func_q == FN_READ) ? ST_BAD_INDEX : ST_NOOP;
      end
      S_CHECK: begin
        ins_q    <= ins_c;
        newtot_q <= ins_c ? docsum_c[OFFSET_BITS-1:0] : rest_c;
        if (func_q == FN_ADOPT) begin
          status_q <= adopt_ok_c ? ST_APPLIED : ST_CONFLICT;
        end else if (noop_c) begin
          status_q <= ST_NOOP;
        end else if (ovf_c) begin
          status_q <= ST_OVERFLOW;
        end
      end
      S_END: end_q <= done_q + rd_pc.len;
      S_INS: begin
        rskip_q <= (done_q >= e_q) ? '0 : (e_q - done_q);
        if (emit.vld) insd_q <= 1'b1;
      end
      S_RIGHT: begin
        done_q <= end_q;
        idx_q  <= idx_q + 1'b1;
      end
      S_TAIL:   if (emit.vld) insd_q <= 1'b1;
      S_COMMIT: status_q <= movf ? ST_OVERFLOW : ST_APPLIED;
      S_RDE2: begin
        ent_q    <= rd_pc;
        status_q <= ST_APPLIED;
      end
      S_DONE: begin
        if (out_free) begin
          rsp_status_q <= status_q;
          rsp_len_q    <= total_q;
          rsp_cnt_q    <= fill_q;
          rsp_ver_q    <= ver_q;
          rsp_ent_q    <= ent_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid        = rsp_vld_q;
  assign rsp.status       = rsp_status_q;
  assign rsp.doc_length   = rsp_len_q;
  assign rsp.entry_count  = rsp_cnt_q;
  assign rsp.doc_version  = rsp_ver_q;
  assign rsp.entry_source = rsp_ent_q.src;
  assign rsp.entry_start  = rsp_ent_q.beg;
  assign rsp.entry_length = rsp_ent_q.len;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_PIECES))
    else $error("piece count beyond table depth");

  a_commit_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> ver_q == $past(ver_q) + 1'b1)
    else $error("applied edit did not bump version");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req.ready)
    else $error("request taken while an edit is in flight");

endmodule

[verif/pte_tb_if.sv]
// Testbench package: the predicted response record.
`timescale 1ns / 1ps
package pte_tb_pkg;
  import pte_pkg::*;

  // One predicted response.
  typedef struct {
    status_e st;
    off_t    doc_len;
    cnt_t    count;
    off_t    version;
    logic    esrc;
    off_t    ebeg;
    off_t    elen;
  } reply_t;
endpackage

[verif/piece_table_edit_engine_tb.sv]
// Testbench of the piece table edit engine: random and directed edits, checked by a model.
`timescale 1ns / 1ps
module piece_table_edit_engine_tb import pte_pkg::*, pte_tb_pkg::*; ();

  localparam longint OFF_LIMIT = 64'hFFFF_FFFF;
  localparam int     WD_LIMIT  = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  pte_req_if req ();
  pte_rsp_if rsp ();

  piece_table_edit_engine DUT (.clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp));

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow state of the table.
  logic   tbl_src[$];
  longint tbl_beg[$];
  longint tbl_len[$];
  longint doc_total, add_used;
  logic [31:0] doc_ver;
  reply_t replies_due[$];
  int failures = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit rsp_stall_off = 0;

  // Split the working table at offset at; return index after the cut.
  function automatic int split_at(ref logic s[$], ref longint b[$], ref longint l[$],
                                  input longint at, input longint tot);
    longint done, fin, left;
    done = 0;
    if (at == 0) return 0;
    if (at >= tot) return s.size();
    for (int i = 0; i < s.size(); i++) begin
      fin = done + l[i];
      if (at == done) return i;
      if (at == fin) return i + 1;
      if (at > done && at < fin) begin
        left = at - done;
        s.insert(i + 1, s[i]);
        b.insert(i + 1, b[i] + left);
        l.insert(i + 1, l[i] - left);
        l[i] = left;
        return i + 1;
      end
      done = fin;
    end
    return s.size();
  endfunction

  // Drop empty pieces and merge contiguous neighbors.
  function automatic void merge_pieces(ref logic s[$], ref longint b[$], ref longint l[$]);
    logic   ns[$];
    longint nb[$], nl[$];
    int k;
    for (int r = 0; r < s.size(); r++) begin
      if (l[r] == 0) continue;
      k = ns.size();
      if (k > 0 && ns[k-1] == s[r] && nb[k-1] + nl[k-1] == b[r]) nl[k-1] += l[r];
      else begin
        ns.insert(k, s[r]); nb.insert(k, b[r]); nl.insert(k, l[r]);
      end
    end
    s = ns; b = nb; l = nl;
  endfunction

  // Apply one request to the shadow table and return its response.
  function automatic reply_t edit_table(func_e fn, longint pa, longint pb, longint tl,
                                        logic [31:0] ev);
    reply_t r;
    logic   ws[$];
    longint wb[$], wl[$];
    longint s, e, t, cut, wt;
    int ia, ib;
    bit ins;
    r = '{st: ST_NOOP, default: '0};
    if (fn == FN_INSERT || fn == FN_ERASE || fn == FN_REPLACE) begin
      s = pa < doc_total ? pa : doc_total;
      e = pb < doc_total ? pb : doc_total;
      if (fn == FN_INSERT) e = s;
      if (e < s) begin t = s; s = e; e = t; end
      cut = e - s;
      ins = fn != FN_ERASE && tl != 0;
      if (cut == 0 && !ins) r.st = ST_NOOP;
      else if (ins && (tl > OFF_LIMIT - add_used || tl > OFF_LIMIT - (doc_total - cut)))
        r.st = ST_OVERFLOW;
      else begin
        ws = tbl_src; wb = tbl_beg; wl = tbl_len; wt = doc_total;
        if (cut != 0) begin
          ia = split_at(ws, wb, wl, s, wt);
          ib = split_at(ws, wb, wl, e, wt);
          for (int i = ia; i < ib; i++) begin
            ws.delete(ia); wb.delete(ia); wl.delete(ia);
          end
          wt -= cut;
          merge_pieces(ws, wb, wl);
        end
        if (ins) begin
          ia = split_at(ws, wb, wl, s, wt);
          ws.insert(ia, 1'b1); wb.insert(ia, add_used); wl.insert(ia, tl);
          wt += tl;
          merge_pieces(ws, wb, wl);
        end
        if (ws.size() > MAX_PIECES) r.st = ST_OVERFLOW;
        else begin
          tbl_src = ws; tbl_beg = wb; tbl_len = wl; doc_total = wt;
          if (ins) add_used += tl;
          doc_ver++;
          r.st = ST_APPLIED;
        end
      end
    end else if (fn == FN_READ) begin
      if (pa < tbl_src.size()) begin
        r.esrc = tbl_src[pa];
        r.ebeg = off_t'(tbl_beg[pa]);
        r.elen = off_t'(tbl_len[pa]);
        r.st = ST_APPLIED;
      end else r.st = ST_BAD_INDEX;
    end else if (fn == FN_ADOPT) begin
      if (ev != doc_ver) r.st = ST_CONFLICT;
      else begin
        tbl_src.delete(); tbl_beg.delete(); tbl_len.delete();
        if (tl != 0) begin
          tbl_src.insert(0, 1'b0); tbl_beg.insert(0, 0); tbl_len.insert(0, tl);
        end
        doc_total = tl;
        add_used = 0;
        doc_ver++;
        r.st = ST_APPLIED;
      end
    end
    r.doc_len = off_t'(doc_total);
    r.count = cnt_t'(tbl_src.size());
    r.version = doc_ver;
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one request and queue its predicted response.
  task automatic send_request(logic [2:0] fn, logic [31:0] pa, logic [31:0] pb,
                              logic [31:0] tl, logic [31:0] ev);
    int gap;
    gap = pick_gap();
    repeat (gap + 1) @(posedge clk_i);
    req.valid <= 1'b1;
    req.func <= fn;
    req.pos_a <= pa;
    req.pos_b <= pb;
    req.text_len <= tl;
    req.expected_version <= ev;
    do @(posedge clk_i); while (!req.ready);
    replies_due.insert(replies_due.size(), edit_table(func_e'(fn), pa, pb, tl, ev));
    req.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return $urandom();
      default: return (doc_total == 0) ? 0 : $urandom_range(0, 32'(doc_total));
    endcase
  endfunction

  task automatic test_directed();
    send_request(FN_READ, 0, 0, 0, 0);
    send_request(FN_ERASE, 0, 5, 0, 0);
    send_request(FN_INSERT, 0, 0, 0, 0);
    send_request(FN_ADOPT, 0, 0, 100, 7);
    send_request(FN_ADOPT, 0, 0, 100, 0);
    send_request(FN_ADOPT, 0, 0, 100, 1);
    send_request(FN_INSERT, 50, 0, 10, 0);
    send_request(FN_INSERT, 32'hFFFF_FFFF, 0, 5, 0);
    send_request(FN_INSERT, 60, 0, 32'hFFFF_FFFF, 0);
    send_request(FN_ERASE, 80, 20, 0, 0);
    send_request(FN_REPLACE, 10, 10, 0, 0);
    send_request(FN_REPLACE, 30, 5, 4, 0);
    send_request(3'd5, 0, 0, 0, 0);
    send_request(3'd6, 1, 2, 3, 4);
    send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 5; i++) send_request(FN_READ, i, 0, 0, 0);
    send_request(FN_READ, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(FN_ADOPT, 0, 0, 32'hFFFF_FFFF, doc_ver);
    send_request(FN_INSERT, 0, 0, 1, 0);
    send_request(FN_ADOPT, 0, 0, 0, doc_ver);
    send_request(FN_READ, 0, 0, 0, 0);
  endtask

  // Fragment the table with small scattered inserts to reach table overflow.
  task automatic test_fill_table();
    send_request(FN_ADOPT, 0, 0, 1000, doc_ver);
    for (int i = 0; i < 45; i++)
      send_request(FN_INSERT, $urandom_range(0, 32'(doc_total)), 0, $urandom_range(1, 3), 0);
    wait_drained();
    for (int i = 0; i < 12; i++) send_request(FN_READ, $urandom_range(0, 70), 0, 0, 0);
  endtask

  task automatic test_random(int n);
    logic [2:0] fn;
    logic [31:0] tl;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: fn = FN_ADOPT;
        1: fn = 3'($urandom_range(5, 7));
        2, 3, 4, 5, 6, 7: fn = FN_INSERT;
        8, 9, 10, 11: fn = FN_ERASE;
        12, 13, 14: fn = FN_REPLACE;
        default: fn = FN_READ;
      endcase
      tl = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 40);
      if (fn == FN_ADOPT) begin
        tl = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2000);
        send_request(fn, $urandom(), $urandom(), tl,
                     ($urandom_range(0, 4) == 0) ? $urandom() : doc_ver);
      end else if (fn == FN_READ)
        send_request(fn, ($urandom_range(0, 9) == 0) ? $urandom()
                     : $urandom_range(0, tbl_src.size()), $urandom(), $urandom(), $urandom());
      else
        send_request(fn, rand_pos(), rand_pos(), tl, $urandom());
      if (i == n / 2) wait_drained();
    end
  endtask

  // Stall the response side at random, mostly short and now and then long.
  always @(posedge clk_i) begin
    if (rsp_stall_off) rsp.ready <= 1'b1;
    else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 7) rsp.ready <= 1'b1;
    else begin
      rsp.ready <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // Compare each response with the oldest prediction.
  always @(posedge clk_i) begin
    reply_t x;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (replies_due.size() == 0) begin
        $error("response with none expected");
        failures++;
      end else begin
        x = replies_due.pop_front();
        if (rsp.status !== x.st) begin
          $error("status exp %0d got %0d", x.st, rsp.status); failures++;
        end
        if (rsp.doc_length !== x.doc_len) begin
          $error("doc_length exp %0d got %0d", x.doc_len, rsp.doc_length); failures++;
        end
        if (rsp.entry_count !== x.count) begin
          $error("entry_count exp %0d got %0d", x.count, rsp.entry_count); failures++;
        end
        if (rsp.doc_version !== x.version) begin
          $error("doc_version exp %0d got %0d", x.version, rsp.doc_version); failures++;
        end
        if (rsp.entry_source !== x.esrc) begin
          $error("entry_source exp %0d got %0d", x.esrc, rsp.entry_source); failures++;
        end
        if (rsp.entry_start !== x.ebeg) begin
          $error("entry_start exp %0d got %0d", x.ebeg, rsp.entry_start); failures++;
        end
        if (rsp.entry_length !== x.elen) begin
          $error("entry_length exp %0d got %0d", x.elen, rsp.entry_length); failures++;
        end
      end
    end
  end

  // End the run when nothing is accepted for too long.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.func = '0;
    req.pos_a = '0;
    req.pos_b = '0;
    req.text_len = '0;
    req.expected_version = '0;
    doc_total = 0;
    add_used = 0;
    doc_ver = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_table();
    test_random(720);
    wait_drained();
    rsp_stall_off = 1;
    repeat (600) @(posedge clk_i);
    if (failures == 0 && replies_due.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

[piece_table_edit_engine.f]
sv/pte_pkg.sv
sv/pte_if.sv
sv/pte_ram.sv
sv/pte_merge.sv
sv/piece_table_edit_engine.sv
verif/pte_tb_if.sv
verif/piece_table_edit_engine_tb.sv
